/* rtl/envgen_pkg.sv */
// ----------------------------------------------------------------------------
// envgen_pkg
// Constants and register indexes for the multi-voice envelope generator.
// ----------------------------------------------------------------------------
package envgen_pkg;

    localparam int LEVEL_W   = 25;
    localparam int ENV_W     = 15;
    localparam int SUSTAIN_W = 7;
    localparam int PERIOD_W  = 32;
    localparam int VOICE_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // attack aims at 1.5 * 2^24 and ends once the level reaches 2^24
    localparam logic [LEVEL_W-1:0] ATTACK_TARGET = LEVEL_W'((1 << 24) + (1 << 23));
    localparam logic [LEVEL_W-1:0] ATTACK_END    = LEVEL_W'(1 << 24);

    localparam int SUSTAIN_SHIFT = 18;
    localparam int STEP_SHIFT    = 5;
    localparam int OUT_SHIFT     = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUSTAIN_LEVEL = 1'b0,
        CFG_DECAY_PERIOD  = 1'b1
    } t_cfg_index;

endpackage

/* rtl/envelope_generator_multi_voice_top.sv */
// ----------------------------------------------------------------------------
// envelope_generator_multi_voice_top
// Time-multiplexed attack/decay/sustain envelope for VOICES voices.
// ----------------------------------------------------------------------------
// Pipeline: input register, then update logic into the result register.
// Throughput: one beat per cycle while the output is not held by i_out_ready;
// the per-voice state is written back in the same cycle it is read, so beats
// for the same voice may follow back to back.
// Reset: synchronous, active low; clears all voice state, the config registers and both valid flags.
// ----------------------------------------------------------------------------
module envelope_generator_multi_voice_top
    import envgen_pkg::*;
#(
    parameter int VOICES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [VOICE_W-1:0]   i_voice,
    input  logic                 i_gate,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ENV_W-1:0]     o_envelope_level
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    // configuration registers
    logic [SUSTAIN_W-1:0] r_sustain_level;
    logic [PERIOD_W-1:0]  r_decay_period;

    // per-voice state
    logic [LEVEL_W-1:0]  r_level       [VOICES];
    logic                r_prev_gate   [VOICES];
    logic                r_in_attack   [VOICES];
    logic [PERIOD_W-1:0] r_decay_count [VOICES];

    // input stage
    logic               r_s1_valid;
    logic [VOICE_W-1:0] r_s1_voice;
    logic               r_s1_gate;

    // result stage
    logic               r_out_valid;
    logic [ENV_W-1:0]   r_env;

    logic s1_adv;
    logic in_fire;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    // ---------------- update logic ----------------
    logic [31:0]         voice_ext;
    logic                voice_ok;
    logic [VIDX_W-1:0]   vidx;
    logic [LEVEL_W-1:0]  lv;
    logic                n_attack;
    logic [LEVEL_W-1:0]  target;
    logic [PERIOD_W-1:0] cnt_inc;
    logic [PERIOD_W-1:0] n_count;
    logic [LEVEL_W-1:0]  diff;
    logic [LEVEL_W:0]    dec_round;
    logic [LEVEL_W-1:0]  n_level;
    logic [ENV_W-1:0]    n_env;

    always_comb begin
        voice_ext = 32'(r_s1_voice);
        voice_ok  = voice_ext < 32'(VOICES);
        vidx      = voice_ext[VIDX_W-1:0];
        lv        = r_level[vidx];

        n_attack = r_in_attack[vidx];
        if (!r_prev_gate[vidx] && r_s1_gate) begin
            n_attack = 1'b1;
        end
        if (!(lv < ATTACK_END && r_s1_gate)) begin
            n_attack = 1'b0;
        end

        target    = r_s1_gate ? (LEVEL_W'(r_sustain_level) << SUSTAIN_SHIFT) : '0;
        cnt_inc   = r_decay_count[vidx] + PERIOD_W'(1);
        n_count   = (cnt_inc < r_decay_period) ? cnt_inc : '0;
        diff      = lv - target;
        // ceil(diff / 32)
        dec_round = ({1'b0, diff} + (LEVEL_W+1)'(31)) >> STEP_SHIFT;

        if (n_attack) begin
            n_count = r_decay_count[vidx];
            n_level = lv + ((ATTACK_TARGET - lv) >> STEP_SHIFT);
        end else if (lv > target && n_count == '0) begin
            n_level = lv - dec_round[LEVEL_W-1:0];
        end else begin
            n_level = lv;
        end

        n_env = voice_ok ? n_level[LEVEL_W-1:OUT_SHIFT] : '0;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sustain_level <= '0;
            r_decay_period  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_data[SUSTAIN_W-1:0];
                CFG_DECAY_PERIOD:  r_decay_period  <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_level[v]       <= '0;
                r_prev_gate[v]   <= 1'b0;
                r_in_attack[v]   <= 1'b0;
                r_decay_count[v] <= '0;
            end
        end else if (s1_adv && voice_ok) begin
            r_level[vidx]       <= n_level;
            r_prev_gate[vidx]   <= r_s1_gate;
            r_in_attack[vidx]   <= n_attack;
            r_decay_count[vidx] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_voice <= i_voice;
            r_s1_gate  <= i_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_env <= n_env;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_envelope_level = r_env;

endmodule

/* test/tb_envelope_generator_multi_voice_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_envelope_generator_multi_voice_top
// Self-checking bench for the four-voice envelope generator. A clocked driver
// feeds voice/gate ticks from a queue, a cycle-accurate predictor computes
// each voice's next level, and a clocked monitor checks every output beat.
// Runs directed ticks, then per-voice note sequences under several register
// settings, with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_envelope_generator_multi_voice_top;
    import envgen_pkg::*;

    localparam int NUM_VOICES  = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_TICKS = 240;

    typedef struct {
        logic [VOICE_W-1:0] voice;
        logic               gate;
    } t_tick;

    typedef struct {
        logic [VOICE_W-1:0] voice;
        logic [ENV_W-1:0]   env;
    } t_env_expect;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [VOICE_W-1:0]   i_voice = '0;
    logic                 i_gate = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ENV_W-1:0]     o_envelope_level;

    envelope_generator_multi_voice_top #(.VOICES(NUM_VOICES)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_voice         (i_voice),
        .i_gate          (i_gate),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_envelope_level(o_envelope_level)
    );

    // predictor state
    logic [LEVEL_W-1:0]   env_level [NUM_VOICES];
    logic                 prev_gate [NUM_VOICES];
    logic                 attacking [NUM_VOICES];
    logic [PERIOD_W-1:0]  decay_cnt [NUM_VOICES];
    logic [SUSTAIN_W-1:0] sustain_reg = '0;
    logic [PERIOD_W-1:0]  period_reg = '0;

    t_tick       tick_q [$];
    t_env_expect env_expect_q [$];

    int errors = 0;
    int input_beats = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 35;
    int recv_idle_pct = 35;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // per-voice note schedule for the random part
    bit note_on [NUM_VOICES];
    int note_left [NUM_VOICES];

    initial begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            env_level[v] = '0;
            prev_gate[v] = 1'b0;
            attacking[v] = 1'b0;
            decay_cnt[v] = '0;
            note_on[v] = 1'b0;
            note_left[v] = 0;
        end
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // one envelope step for one voice; returns the expected output
    function automatic logic [ENV_W-1:0] step_envelope(input logic [VOICE_W-1:0] v,
                                                       input logic g);
        logic [31:0] lv;
        logic [31:0] tgt;
        logic [31:0] cnt;
        logic [31:0] diff;
        lv = 32'(env_level[v]);
        if (!prev_gate[v] && g)
            attacking[v] = 1'b1;
        if (!(lv < 32'(ATTACK_END) && g))
            attacking[v] = 1'b0;
        prev_gate[v] = g;
        if (attacking[v]) begin
            lv = lv + ((32'(ATTACK_TARGET) - lv) >> STEP_SHIFT);
        end else begin
            tgt = g ? (32'(sustain_reg) << SUSTAIN_SHIFT) : 32'd0;
            cnt = decay_cnt[v] + 32'd1;
            if (!(cnt < period_reg))
                cnt = '0;
            decay_cnt[v] = cnt;
            // step rounds up so the level settles exactly on the target
            if (lv > tgt && cnt == 0) begin
                diff = lv - tgt;
                lv = lv - ((diff + 32'd31) >> STEP_SHIFT);
            end
        end
        env_level[v] = lv[LEVEL_W-1:0];
        return ENV_W'(lv[LEVEL_W-1:0] >> OUT_SHIFT);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_tick nxt;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                env_expect_q.push_back('{voice: i_voice, env: step_envelope(i_voice, i_gate)});
                input_beats++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = tick_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_voice <= nxt.voice;
                    i_gate <= nxt.gate;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && input_beats >= 600) begin
            hold_done = 1'b1;
            hold_left = 300;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_env_expect exp_beat;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (env_expect_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual envelope_level %0d",
                         $time, o_envelope_level);
                errors++;
            end else begin
                exp_beat = env_expect_q.pop_front();
                if (o_envelope_level !== exp_beat.env) begin
                    $display("%0t: envelope_level mismatch (voice %0d) expected %0d actual %0d",
                             $time, exp_beat.voice, exp_beat.env, o_envelope_level);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("envelope_generator_multi_voice_top test failed");
            $finish;
        end
    end

    task automatic add_tick(input int v, input bit g);
        tick_q.push_back('{voice: VOICE_W'(v), gate: g});
    endtask

    // note-on/note-off runs per voice, with some random gate noise mixed in
    task automatic add_notes(input int n);
        int v;
        bit g;
        for (int k = 0; k < n; k++) begin
            v = $urandom_range(NUM_VOICES - 1);
            if ($urandom_range(99) < 12) begin
                g = 1'($urandom_range(1));
            end else begin
                if (note_left[v] == 0) begin
                    note_on[v] = !note_on[v];
                    if (note_on[v])
                        note_left[v] = ($urandom_range(9) == 0) ? $urandom_range(150, 400)
                                                                : $urandom_range(1, 60);
                    else
                        note_left[v] = $urandom_range(1, 50);
                end
                note_left[v]--;
                g = note_on[v];
            end
            add_tick(v, g);
        end
    endtask

    task automatic drain;
        while (tick_q.size() != 0 || i_in_valid || env_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_SUSTAIN_LEVEL)
            sustain_reg = data[SUSTAIN_W-1:0];
        else
            period_reg = data;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at reset settings: rise, drop mid-attack, retrigger,
        // low gate at zero level, all voices
        add_tick(0, 1); add_tick(0, 1); add_tick(0, 0); add_tick(0, 0);
        add_tick(0, 1); add_tick(0, 1); add_tick(1, 0); add_tick(1, 1);
        add_tick(1, 0); add_tick(1, 1); add_tick(2, 1); add_tick(3, 1);
        add_tick(3, 1); add_tick(3, 0); add_tick(2, 0); add_tick(2, 0);
        add_tick(3, 0); add_tick(0, 0);
        add_notes(PHASE_TICKS);
        drain();

        // sustain above the attack end: level holds after the attack
        write_reg(CFG_SUSTAIN_LEVEL, 32'hFFFF_FF7F);
        write_reg(CFG_DECAY_PERIOD, 32'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_notes(PHASE_TICKS);
        drain();

        send_idle_pct = 35;
        recv_idle_pct = 35;
        write_reg(CFG_SUSTAIN_LEVEL, 32'd64);
        write_reg(CFG_DECAY_PERIOD, 32'd3);
        add_notes(PHASE_TICKS);
        drain();

        // decay effectively never steps
        write_reg(CFG_SUSTAIN_LEVEL, 32'd0);
        write_reg(CFG_DECAY_PERIOD, 32'hFFFF_FFFF);
        add_notes(PHASE_TICKS);
        drain();

        write_reg(CFG_SUSTAIN_LEVEL, 32'($urandom_range(64)));
        write_reg(CFG_DECAY_PERIOD, 32'($urandom_range(7)));
        add_notes(PHASE_TICKS);
        drain();

        write_reg(CFG_DECAY_PERIOD, 32'd0);
        write_reg(CFG_SUSTAIN_LEVEL, 32'd32);
        add_notes(PHASE_TICKS);
        drain();

        repeat (20) @(posedge i_clk);
        if (errors == 0 && env_expect_q.size() == 0)
            $display("envelope_generator_multi_voice_top test passed");
        else
            $display("envelope_generator_multi_voice_top test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/envgen_pkg.sv
rtl/envelope_generator_multi_voice_top.sv
test/tb_envelope_generator_multi_voice_top.sv
